// ===== design/rnma_pkg.sv =====
package rnma_pkg;

    // Result status codes.
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_BAD_DIGIT   = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG    = 2'd2;

    // Character codes and base limits.
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_NONE    = 8'hFF;
    localparam logic [5:0] RADIX_MIN    = 6'd2;
    localparam logic [5:0] RADIX_MAX    = 6'd36;
    localparam logic [5:0] RADIX_RESET  = 6'd10;
    localparam logic [5:0] DECIMAL_TEN  = 6'd10;

    // Depth of the queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 4;

    // One classified character as it travels from front to back.
    typedef struct packed {
        logic [5:0] digit;
        logic       bad;
        logic       eop;
        logic       eos;
    } q_entry_t;

    // Digit value of an ASCII character, CHAR_NONE when it is no digit.
    function automatic logic [7:0] char_value(input logic [7:0] c);
        logic [7:0] v;
        v = CHAR_NONE;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = c - CHAR_ZERO;
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            v = c - CHAR_UPPER_A + 8'(DECIMAL_TEN);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            v = c - CHAR_LOWER_A + 8'(DECIMAL_TEN);
        end
        return v;
    endfunction

    // Uppercase ASCII character of a digit value.
    function automatic logic [6:0] value_char(input logic [5:0] d);
        logic [6:0] c;
        if (d < DECIMAL_TEN) begin
            c = CHAR_ZERO[6:0] + 7'(d);
        end else begin
            c = CHAR_UPPER_A[6:0] + 7'(d) - 7'(DECIMAL_TEN);
        end
        return c;
    endfunction

endpackage

// ===== design/rnma_ram.sv =====
module rnma_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rnma_front.sv =====
module rnma_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [5:0]        cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              s_tuser,
    input  logic              q_full,
    output logic              q_push,
    output rnma_pkg::q_entry_t q_entry,
    output logic [5:0]        base
);
    import rnma_pkg::*;

    logic [5:0] radix_reg;
    logic [7:0] value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_wr_en) begin
            radix_reg <= cfg_wr_data;
        end
    end

    // Out-of-range bases are clamped to the nearest legal one.
    always_comb begin
        if (radix_reg < RADIX_MIN) begin
            base = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            base = RADIX_MAX;
        end else begin
            base = radix_reg;
        end
    end

    assign value         = char_value(s_tdata);
    assign q_entry.digit = value[5:0];
    assign q_entry.bad   = (value >= {2'b00, base});
    assign q_entry.eop   = s_tlast;
    assign q_entry.eos   = s_tuser;
    assign s_tready      = !q_full;
    assign q_push        = s_tvalid && !q_full;

endmodule

// ===== design/rnma_queue.sv =====
module rnma_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  rnma_pkg::q_entry_t push_entry,
    output logic               full,
    input  logic               pop,
    output rnma_pkg::q_entry_t pop_entry,
    output logic               empty
);
    import rnma_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    q_entry_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_pop;

    assign full      = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_pop    = pop && !empty;
    assign pop_entry = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/rnma_back.sv =====
module rnma_back #(
    parameter int MAX_DIGITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [5:0]         base,
    input  logic               q_empty,
    input  rnma_pkg::q_entry_t q_entry,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast,
    output logic [1:0]         m_tuser
);
    import rnma_pkg::*;

    localparam int LEN_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_FOLD_RD   = 3'd1;
    localparam logic [2:0] S_FOLD_WR   = 3'd2;
    localparam logic [2:0] S_CARRY     = 3'd3;
    localparam logic [2:0] S_ERR_OUT   = 3'd4;
    localparam logic [2:0] S_EMIT_RD   = 3'd5;
    localparam logic [2:0] S_EMIT_WAIT = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [LEN_W-1:0] acc_len_reg, acc_len_next;
    logic [LEN_W-1:0] op_len_reg, op_len_next;
    logic [1:0]       err_reg, err_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic             carry_reg, carry_next;
    logic             eos_reg, eos_next;
    logic [IDX_W-1:0] emit_idx_reg, emit_idx_next;

    logic             out_valid_reg, out_valid_next;
    logic [6:0]       out_char_reg, out_char_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic             out_last_reg, out_last_next;
    logic             out_free;

    logic             op_we;
    logic [IDX_W-1:0] op_raddr;
    logic [5:0]       op_rdata;
    logic             acc_we;
    logic [IDX_W-1:0] acc_waddr, acc_raddr;
    logic [5:0]       acc_wdata, acc_rdata;

    logic [LEN_W-1:0] width;
    logic [LEN_W-1:0] op_pos;
    logic [6:0]       sum;
    logic [6:0]       sum_wrapped;
    logic             sum_carry;
    logic [1:0]       char_err;

    rnma_ram #(.WIDTH(6), .DEPTH(MAX_DIGITS)) u_op_ram (
        .aclk  (aclk),
        .we    (op_we),
        .waddr (op_len_reg[IDX_W-1:0]),
        .wdata (q_entry.digit),
        .raddr (op_raddr),
        .rdata (op_rdata)
    );

    rnma_ram #(.WIDTH(6), .DEPTH(MAX_DIGITS)) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign width    = (acc_len_reg > op_len_reg) ? acc_len_reg : op_len_reg;
    // Operand digits are stored most significant first; walk them from the end.
    assign op_pos   = op_len_reg - 1'b1 - pos_reg;
    assign op_raddr = op_pos[IDX_W-1:0];

    always_comb begin
        if (state_reg == S_EMIT_RD || state_reg == S_EMIT_WAIT) begin
            acc_raddr = emit_idx_reg;
        end else begin
            acc_raddr = pos_reg[IDX_W-1:0];
        end
    end

    // Entries beyond either length count as zero. The sum stays below twice
    // the base, so one compare and subtract gives digit and carry.
    always_comb begin
        sum = 7'(carry_reg);
        if (pos_reg < acc_len_reg) begin
            sum = sum + 7'(acc_rdata);
        end
        if (pos_reg < op_len_reg) begin
            sum = sum + 7'(op_rdata);
        end
        sum_carry   = (sum >= 7'(base));
        sum_wrapped = sum_carry ? (sum - 7'(base)) : sum;
    end

    always_comb begin
        if (q_entry.bad) begin
            char_err = STATUS_BAD_DIGIT;
        end else if (op_len_reg == LEN_W'(MAX_DIGITS)) begin
            char_err = STATUS_TOO_LONG;
        end else begin
            char_err = STATUS_OK;
        end
    end

    always_comb begin
        state_next      = state_reg;
        acc_len_next    = acc_len_reg;
        op_len_next     = op_len_reg;
        err_next        = err_reg;
        pos_next        = pos_reg;
        carry_next      = carry_reg;
        eos_next        = eos_reg;
        emit_idx_next   = emit_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_char_next   = out_char_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        op_we           = 1'b0;
        acc_we          = 1'b0;
        acc_waddr       = pos_reg[IDX_W-1:0];
        acc_wdata       = sum_wrapped[5:0];

        unique case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (err_reg == STATUS_OK) begin
                        err_next = char_err;
                        if (char_err == STATUS_OK) begin
                            op_we       = 1'b1;
                            op_len_next = op_len_reg + 1'b1;
                        end
                    end
                    if (q_entry.eop) begin
                        if (err_next == STATUS_OK) begin
                            pos_next   = '0;
                            carry_next = 1'b0;
                            eos_next   = q_entry.eos;
                            state_next = S_FOLD_RD;
                        end else begin
                            op_len_next = '0;
                            if (q_entry.eos) begin
                                state_next = S_ERR_OUT;
                            end
                        end
                    end
                end
            end
            S_FOLD_RD: begin
                state_next = S_FOLD_WR;
            end
            S_FOLD_WR: begin
                acc_we     = 1'b1;
                carry_next = sum_carry;
                pos_next   = pos_reg + 1'b1;
                state_next = S_FOLD_RD;
                if (pos_reg + 1'b1 == width) begin
                    acc_len_next  = width;
                    op_len_next   = '0;
                    emit_idx_next = IDX_W'(width - 1'b1);
                    if (sum_carry && width == LEN_W'(MAX_DIGITS)) begin
                        err_next   = STATUS_TOO_LONG;
                        state_next = eos_reg ? S_ERR_OUT : S_IDLE;
                    end else if (sum_carry) begin
                        state_next = S_CARRY;
                    end else begin
                        state_next = eos_reg ? S_EMIT_RD : S_IDLE;
                    end
                end
            end
            S_CARRY: begin
                acc_we        = 1'b1;
                acc_waddr     = acc_len_reg[IDX_W-1:0];
                acc_wdata     = 6'd1;
                acc_len_next  = acc_len_reg + 1'b1;
                emit_idx_next = acc_len_reg[IDX_W-1:0];
                state_next    = eos_reg ? S_EMIT_RD : S_IDLE;
            end
            S_ERR_OUT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_char_next   = '0;
                    out_status_next = err_reg;
                    out_last_next   = 1'b1;
                    acc_len_next    = '0;
                    op_len_next     = '0;
                    err_next        = STATUS_OK;
                    state_next      = S_IDLE;
                end
            end
            S_EMIT_RD: begin
                state_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_char_next   = value_char(acc_rdata);
                    out_status_next = STATUS_OK;
                    out_last_next   = (emit_idx_reg == '0);
                    if (emit_idx_reg == '0) begin
                        acc_len_next = '0;
                        op_len_next  = '0;
                        err_next     = STATUS_OK;
                        state_next   = S_IDLE;
                    end else begin
                        emit_idx_next = emit_idx_reg - 1'b1;
                        state_next    = S_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            acc_len_reg   <= '0;
            op_len_reg    <= '0;
            err_reg       <= STATUS_OK;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            acc_len_reg   <= acc_len_next;
            op_len_reg    <= op_len_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        carry_reg      <= carry_next;
        eos_reg        <= eos_next;
        emit_idx_reg   <= emit_idx_next;
        out_char_reg   <= out_char_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

endmodule

// ===== design/radix_n_multi_operand_adder.sv =====
// Multi-operand adder for numbers written as ASCII digit strings in base 2 to 36.
// The input stream carries one character per word, most significant first;
// s_tlast ends an operand and s_tuser together with s_tlast ends the sum.
// The result stream carries the sum as uppercase characters, most significant
// first, with m_tlast on the final word; m_tuser is the status. An invalid
// digit or an over-long operand or sum yields one word with status set.
// The base is written through cfg_wr_en / cfg_wr_data while the block is idle;
// the user must keep to this, the block does not enforce it. A front stage
// classifies each character and places it in a four-word queue; the back
// sequencer takes one queued character per cycle while idle. At an operand end it
// walks the digit accumulator, reading then writing each digit over the wider of
// the two lengths, plus one write on a final carry. The sum leaves one character
// at a time, each read first. These loops run through the two digit RAMs, each
// with one write and one registered read per cycle. A synchronous reset clears
// the sequencer, the queue and the output register, and sets the base to ten.
// When the receiver stalls, the result word holds and the sequencer waits;
// characters keep filling the queue until it is full, and then s_tready drops.
module radix_n_multi_operand_adder #(
    parameter int MAX_DIGITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Base register write port.
    input  logic       cfg_wr_en,
    input  logic [5:0] cfg_wr_data,
    // Input stream.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] digit_char
    input  logic       s_tlast,   // end_of_operand
    input  logic       s_tuser,   // [0] end_of_sum
    // Result stream.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] sum_char, [7] zero
    output logic       m_tlast,   // last_char
    output logic [1:0] m_tuser    // [1:0] status
);
    import rnma_pkg::*;

    q_entry_t   push_entry;
    q_entry_t   pop_entry;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    logic [5:0] base;

    // The front classifies each character against the current base.
    rnma_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry),
        .base        (base)
    );

    rnma_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    // The back holds the operand and accumulator digits and drives results.
    rnma_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .base     (base),
        .q_empty  (q_empty),
        .q_entry  (pop_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== design/rnma_checker.sv =====
module rnma_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);
    import rnma_pkg::*;

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed while stalled");

    // An error result is the only word of its sum and carries no character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_OK |-> m_tlast && m_tdata == 8'd0)
        else $error("error result is not a lone zero word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == STATUS_OK || m_tuser == STATUS_BAD_DIGIT
            || m_tuser == STATUS_TOO_LONG)
        else $error("undefined status code");

    // Every good result is an uppercase digit character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_OK |->
            (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE)
            || (m_tdata >= CHAR_UPPER_A && m_tdata <= CHAR_UPPER_Z))
        else $error("sum character out of range");

endmodule

bind radix_n_multi_operand_adder rnma_checker u_rnma_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== bench/radix_n_multi_operand_adder_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the multi-operand digit string adder.
// The initial block plans the stimulus phase by phase: it sets the base, picks
// how often each side idles, and fills a queue of pending character words.
// A clocked driver feeds that queue into the input stream. A clocked monitor
// takes result words off the output stream. Every character word that the
// block accepts runs through a behavioral model of the adder here in the
// bench, and the sum words that it predicts wait in a queue for the monitor.
module radix_n_multi_operand_adder_tb;
    import rnma_pkg::*;

    localparam int MAX_DIGITS    = 32;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    // A carry walk reads and then writes each digit, and the emission of a sum
    // reads each one before it goes; this covers both with room to spare.
    localparam int SETTLE_CYCLES = 4 * MAX_DIGITS + 40;
    // Long enough for the four-word queue and the sequencer to fill up.
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 600000;
    // Random characters per phase; whole sums are queued until this is reached.
    localparam int PHASE_ITEMS   = 4;

    // One input word: a character and its two end markers.
    typedef struct packed {
        logic [7:0] ch;
        logic       eop;
        logic       eos;
    } char_word_t;

    // One result word as the bench expects it.
    typedef struct packed {
        logic [6:0] sum_char;
        logic [1:0] status;
        logic       last_char;
    } sum_word_t;

    // Every input of the block is known from time zero.
    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [5:0] cfg_wr_data = '0;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata     = '0;
    logic       s_tlast     = 1'b0;
    logic       s_tuser     = 1'b0;
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    // Stimulus and checking bookkeeping.
    char_word_t pending_chars[$];
    sum_word_t  expected_sum_words[$];
    int unsigned chars_queued       = 0;
    int unsigned mismatch_count     = 0;
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned cycle_count        = 0;

    // The long receiver hold-off. The initial block bumps hold_trigger, and
    // the hold process notices the change and counts the stretch down itself.
    int unsigned hold_trigger = 0;
    int unsigned hold_seen    = 0;
    int unsigned hold_left    = 0;

    // Model state of the adder. The base copy follows every register write.
    logic [5:0]  radix_setting = RADIX_RESET;
    logic [5:0]  acc_digits[MAX_DIGITS];    // units digit at index 0
    int unsigned acc_len       = 0;
    logic [5:0]  opd_digits[MAX_DIGITS];    // most significant digit first
    int unsigned opd_len       = 0;
    bit          first_operand = 1'b1;
    logic [1:0]  sum_error     = STATUS_OK;

    radix_n_multi_operand_adder #(
        .MAX_DIGITS (MAX_DIGITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // [7:0] digit_char
        .s_tlast     (s_tlast),     // end_of_operand
        .s_tuser     (s_tuser),     // [0] end_of_sum
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),     // [6:0] sum_char, [7] zero
        .m_tlast     (m_tlast),     // last_char
        .m_tuser     (m_tuser)      // [1:0] status
    );

    // Out-of-range register values behave like the nearest legal base.
    function automatic int unsigned clamp_radix(input logic [5:0] r);
        if (r < RADIX_MIN) begin
            return RADIX_MIN;
        end
        if (r > RADIX_MAX) begin
            return RADIX_MAX;
        end
        return r;
    endfunction

    // Digit value of a character; 255 for anything that is not alphanumeric.
    // Lowercase letters are folded onto uppercase before the letter test.
    function automatic int unsigned digit_value(input logic [7:0] c);
        logic [7:0] folded;
        folded = c;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            return c - CHAR_ZERO;
        end
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            folded = c - (CHAR_LOWER_A - CHAR_UPPER_A);
        end
        if (folded >= CHAR_UPPER_A && folded <= CHAR_UPPER_Z) begin
            return folded - CHAR_UPPER_A + DECIMAL_TEN;
        end
        return 255;
    endfunction

    // Character of a digit value, with letters in the case asked for.
    function automatic logic [6:0] digit_char(input int unsigned d, input bit lower);
        if (d < DECIMAL_TEN) begin
            return 7'(CHAR_ZERO + d);
        end
        return 7'((lower ? CHAR_LOWER_A : CHAR_UPPER_A) + d - DECIMAL_TEN);
    endfunction

    // Runs one accepted character through the adder model and queues the sum
    // words that it causes. The first error of a sum sticks; later characters
    // and operand ends are then dropped until the end of the sum.
    function automatic void add_char_to_sum(input logic [7:0] c, input logic eop,
                                            input logic eos);
        int unsigned base;
        int unsigned d;
        int unsigned width;
        int unsigned carry;
        int unsigned s;
        sum_word_t   word;
        base = clamp_radix(radix_setting);
        if (sum_error == STATUS_OK) begin
            d = digit_value(c);
            if (d >= base) begin
                sum_error = STATUS_BAD_DIGIT;
            end else if (opd_len >= MAX_DIGITS) begin
                sum_error = STATUS_TOO_LONG;
            end else begin
                opd_digits[opd_len] = 6'(d);
                opd_len++;
            end
        end
        if (!eop) begin
            return;
        end
        // Fold the finished operand into the accumulator, right-aligned.
        if (sum_error == STATUS_OK) begin
            if (first_operand) begin
                for (int i = 0; i < opd_len; i++) begin
                    acc_digits[i] = opd_digits[opd_len - 1 - i];
                end
                acc_len = opd_len;
                first_operand = 1'b0;
            end else begin
                width = (acc_len > opd_len) ? acc_len : opd_len;
                carry = 0;
                for (int i = 0; i < width; i++) begin
                    s = carry;
                    if (i < acc_len) begin
                        s += acc_digits[i];
                    end
                    if (i < opd_len) begin
                        s += opd_digits[opd_len - 1 - i];
                    end
                    acc_digits[i] = 6'(s % base);
                    carry = s / base;
                end
                acc_len = width;
                if (carry != 0) begin
                    if (acc_len >= MAX_DIGITS) begin
                        sum_error = STATUS_TOO_LONG;
                    end else begin
                        acc_digits[acc_len] = 6'(carry);
                        acc_len++;
                    end
                end
            end
        end
        opd_len = 0;
        if (!eos) begin
            return;
        end
        if (sum_error != STATUS_OK) begin
            word.sum_char  = '0;
            word.status    = sum_error;
            word.last_char = 1'b1;
            expected_sum_words.push_back(word);
        end else begin
            for (int k = 0; k < acc_len; k++) begin
                word.sum_char  = digit_char(acc_digits[acc_len - 1 - k], 1'b0);
                word.status    = STATUS_OK;
                word.last_char = (k == acc_len - 1);
                expected_sum_words.push_back(word);
            end
        end
        // The sum is done: everything but the base returns to its reset value.
        acc_len       = 0;
        opd_len       = 0;
        first_operand = 1'b1;
        sum_error     = STATUS_OK;
    endfunction

    function automatic void queue_char(input logic [7:0] c, input bit eop, input bit eos);
        char_word_t word;
        word.ch  = c;
        word.eop = eop;
        word.eos = eos;
        pending_chars.push_back(word);
        chars_queued++;
    endfunction

    // Queues a whole operand from a string, optionally closing the sum.
    function automatic void queue_operand(input string digits, input bit ends_sum);
        for (int i = 0; i < digits.len(); i++) begin
            queue_char(digits[i], i == digits.len() - 1, ends_sum && i == digits.len() - 1);
        end
    endfunction

    // Queues one operand of the given length made of random digits of the base,
    // letters in random case; fixed_digit >= 0 forces every digit to that value.
    function automatic void queue_random_operand(input int unsigned base, input int unsigned len,
                                                 input int fixed_digit, input bit ends_sum);
        int unsigned d;
        for (int i = 0; i < len; i++) begin
            d = (fixed_digit >= 0) ? fixed_digit : $urandom_range(0, base - 1);
            queue_char({1'b0, digit_char(d, $urandom_range(0, 1))}, i == len - 1,
                       ends_sum && i == len - 1);
        end
    endfunction

    // A well-formed sum of one to three operands with random content. Now and
    // then a character is noise or a digit too big for the base, and an early
    // end-of-sum flag without an operand end rides along to be ignored.
    function automatic void queue_random_sum(input int unsigned base);
        int unsigned n_ops;
        int unsigned len;
        logic [7:0]  c;
        bit          eop;
        bit          eos;
        n_ops = $urandom_range(1, 3);
        for (int op = 0; op < n_ops; op++) begin
            len = ($urandom_range(0, 11) == 0) ? $urandom_range(5, 10)
                                               : $urandom_range(1, 3);
            for (int i = 0; i < len; i++) begin
                eop = (i == len - 1);
                eos = eop ? (op == n_ops - 1) : ($urandom_range(0, 7) == 0);
                case ($urandom_range(0, 29))
                    0: begin
                        c = 8'($urandom_range(0, 255));
                    end
                    1: begin
                        c = {1'b0, digit_char($urandom_range(0, 35), $urandom_range(0, 1))};
                    end
                    default: begin
                        c = {1'b0, digit_char($urandom_range(0, base - 1),
                                              $urandom_range(0, 1))};
                    end
                endcase
                queue_char(c, eop, eos);
            end
        end
    endfunction

    // The base register is only written while the block sits idle.
    task automatic write_radix(input logic [5:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        radix_setting = value;
        @(negedge aclk);
    endtask

    // Waits at falling edges, where the queues and the valid are settled,
    // until every pending word has gone in and every expected word came out.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pending_chars.size() != 0 || s_tvalid || expected_sum_words.size() != 0);
    endtask

    // Ends a phase: drain, then give the block time to fall fully idle.
    task automatic finish_phase();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_idling(input int unsigned sender, input int unsigned receiver);
        sender_idle_pct    = sender;
        receiver_stall_pct = receiver;
    endtask

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Driver. At each rising edge a word that was just accepted goes through
    // the model, and the bus is loaded with the next pending word unless the
    // sender chooses to idle. A word on the bus stays until it is taken.
    always @(posedge aclk) begin
        char_word_t next_word;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                add_char_to_sum(s_tdata, s_tlast, s_tuser);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_chars.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    next_word = pending_chars.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_word.ch;
                    s_tlast  <= next_word.eop;
                    s_tuser  <= next_word.eos;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each accepted result word is checked against the oldest
    // expected one; the ready for the next edge is drawn at random, and held
    // low for the whole of a hold-off.
    always @(posedge aclk) begin
        sum_word_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_sum_words.size() == 0) begin
                    $display("%0t: result word with none expected: tdata %h status %0d last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_sum_words.pop_front();
                    if (m_tdata !== {1'b0, want.sum_char} || m_tuser !== want.status ||
                            m_tlast !== want.last_char) begin
                        $display("%0t: expected tdata %h status %0d last %0b, got tdata %h status %0d last %0b",
                                 $time, {1'b0, want.sum_char}, want.status, want.last_char,
                                 m_tdata, m_tuser, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Counts down the long receiver hold-off.
    always @(posedge aclk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Guards against a hang anywhere in the run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [5:0]  random_radixes[6];
        int unsigned base;
        int unsigned phase_start;
        random_radixes = '{6'd0, 6'd1, 6'd37, 6'd63, 6'd7, 6'd10};

        // Synchronous reset, held low from time zero and released at an edge.
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, base ten from reset, no idling.
        set_idling(0, 0);
        queue_operand("9", 1'b0);           // a carry that widens the sum
        queue_operand("1", 1'b1);
        queue_operand("007", 1'b1);         // leading zeros are kept
        queue_operand("5A", 1'b0);          // a letter is no digit in base ten
        queue_operand("3", 1'b1);           // dropped after the error
        queue_char("4", 1'b0, 1'b1);        // end of sum without operand end
        queue_char("2", 1'b1, 1'b1);
        queue_char(8'hFF, 1'b1, 1'b1);      // not alphanumeric at all
        finish_phase();

        // Directed, the largest base: lowercase in, uppercase out.
        write_radix(RADIX_MAX);
        set_idling(77, 0);
        queue_operand("zZ", 1'b0);
        queue_operand("1", 1'b1);
        finish_phase();

        // Directed, the smallest base.
        write_radix(RADIX_MIN);
        set_idling(0, 77);
        queue_operand("1", 1'b0);
        queue_operand("1", 1'b0);
        queue_operand("1", 1'b1);
        queue_operand("2", 1'b1);
        finish_phase();

        // Backpressure in base sixteen: the receiver holds off for a long
        // stretch while a short sum, a sum whose carry runs off the top,
        // and an operand one digit too long are offered, so the queue fills
        // and the input stalls.
        write_radix(6'd16);
        set_idling(0, 0);
        hold_trigger <= hold_trigger + 1;
        queue_random_operand(16, 2, -1, 1'b1);
        queue_random_operand(16, MAX_DIGITS, 15, 1'b0);
        queue_operand("1", 1'b1);
        queue_random_operand(16, MAX_DIGITS + 1, -1, 1'b1);
        finish_phase();

        // Random sums over a range of register values, the out-of-range ones
        // among them, cycling through the idling patterns. In one phase the
        // sender waits for every result before it starts the next sum.
        for (int p = 0; p < 6; p++) begin
            write_radix(random_radixes[p]);
            case (p % 4)
                0: set_idling(0, 0);
                1: set_idling(77, 0);
                2: set_idling(0, 77);
                default: set_idling(26, 26);
            endcase
            base = clamp_radix(random_radixes[p]);
            phase_start = chars_queued;
            while (chars_queued - phase_start < PHASE_ITEMS) begin
                if (p == 4) begin
                    wait_drained();
                end
                queue_random_sum(base);
            end
            finish_phase();
        end

        if (expected_sum_words.size() != 0) begin
            $display("%0t: %0d expected result words never arrived", $time,
                     expected_sum_words.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== radix_n_multi_operand_adder.f =====
design/rnma_pkg.sv
design/rnma_ram.sv
design/rnma_front.sv
design/rnma_queue.sv
design/rnma_back.sv
design/radix_n_multi_operand_adder.sv
design/rnma_checker.sv
bench/radix_n_multi_operand_adder_tb.sv
